// ===== hdl/bnsi_pkg.sv =====
`default_nettype none

package bnsi_pkg;

  // Largest supported base and derived widths
  localparam int MAX_BASE_CHARS_DEF = 16;
  localparam int CHARS_W            = 128;
  localparam int LEN_W              = 5;
  localparam int ACC_W              = 32;
  localparam int CFG_DATA_W         = 64;
  localparam int CFG_ADDR_W         = 5;

  // Special bytes
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Register indexes (byte address is 8 * index)
  typedef enum logic [1:0] {
    REG_CHARS_LOW  = 2'd0,
    REG_CHARS_HIGH = 2'd1,
    REG_LENGTH     = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_SPACE = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_IDLE  = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/bnsi_digit_match.sv =====
`default_nettype none

module bnsi_digit_match #(
  parameter int MAX_BASE_CHARS = bnsi_pkg::MAX_BASE_CHARS_DEF,
  parameter int DIG_W          = $clog2(MAX_BASE_CHARS)
) (
  input  wire logic [bnsi_pkg::CHARS_W-1:0] chars,
  input  wire logic [bnsi_pkg::LEN_W-1:0]   used_len,
  input  wire logic [7:0]                   character,
  output logic                              hit,
  output logic [DIG_W-1:0]                  digit
);
  import bnsi_pkg::*;

  logic [MAX_BASE_CHARS-1:0] match;

  always_comb begin
    for (int k = 0; k < MAX_BASE_CHARS; k++) begin
      match[k] = (LEN_W'(k) < used_len) && (chars[8*k +: 8] == character);
    end
  end

  // Lowest matching index wins
  always_comb begin
    hit   = |match;
    digit = '0;
    for (int k = MAX_BASE_CHARS - 1; k >= 0; k--) begin
      if (match[k]) begin
        digit = DIG_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bnsi_base_check.sv =====
`default_nettype none

module bnsi_base_check #(
  parameter int MAX_BASE_CHARS = bnsi_pkg::MAX_BASE_CHARS_DEF
) (
  input  wire logic [bnsi_pkg::CHARS_W-1:0] chars,
  input  wire logic [bnsi_pkg::LEN_W-1:0]   base_length,
  output logic                              invalid
);
  import bnsi_pkg::*;

  logic [MAX_BASE_CHARS-1:0] bad_char;
  logic [MAX_BASE_CHARS-1:0] dup_char;
  logic                      bad_len;

  assign bad_len = (base_length <= LEN_W'(1)) || (base_length > LEN_W'(MAX_BASE_CHARS));

  always_comb begin
    for (int i = 0; i < MAX_BASE_CHARS; i++) begin
      bad_char[i] = (LEN_W'(i) < base_length) &&
                    ((chars[8*i +: 8] == CHAR_NUL) || (chars[8*i +: 8] == CHAR_PLUS) ||
                     (chars[8*i +: 8] == CHAR_MINUS));
      dup_char[i] = 1'b0;
      for (int j = i + 1; j < MAX_BASE_CHARS; j++) begin
        if ((LEN_W'(j) < base_length) && (chars[8*i +: 8] == chars[8*j +: 8])) begin
          dup_char[i] = 1'b1;
        end
      end
    end
  end

  assign invalid = bad_len || (|bad_char) || (|dup_char);

endmodule

`default_nettype wire

// ===== hdl/base_n_string_to_integer.sv =====
`default_nettype none

// Channel     | Direction | Handshake          | Payload
// ------------+-----------+--------------------+------------------------------------
// in_         | input     | in_valid/in_ready  | in_character[7:0]
// out_        | output    | out_valid/out_ready| out_value[31:0] signed, out_base_invalid
// cfg_        | APB slave | psel/penable/pready| paddr[4:0], pwdata/prdata[63:0]
//
// One byte per cycle sustained: each transaction is latched in an input register,
// then digit match, sign handling and one 32x5 multiply-add update the parse state
// in the following cycle. A zero byte loads the result register; it stalls the
// input register only while a previous result still waits on out_ready.
// Reset (rst_n, synchronous) clears the parse state, valids and configuration.
// Base validity is re-registered from the configuration each cycle.

module base_n_string_to_integer #(
  parameter int MAX_BASE_CHARS = bnsi_pkg::MAX_BASE_CHARS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          in_character,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [bnsi_pkg::ACC_W-1:0]        out_value,
  output logic                                     out_base_invalid,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [bnsi_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [bnsi_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [bnsi_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);
  import bnsi_pkg::*;

  localparam int DIG_W = (MAX_BASE_CHARS > 1) ? $clog2(MAX_BASE_CHARS) : 1;

  // Configuration registers
  logic [CFG_DATA_W-1:0] chars_low_r;
  logic [CFG_DATA_W-1:0] chars_high_r;
  logic [LEN_W-1:0]      base_length_r;
  logic                  base_invalid_r;
  logic                  base_invalid_nxt;
  reg_idx_t              cfg_idx;
  logic                  cfg_wr;
  logic [CHARS_W-1:0]    chars;
  logic [LEN_W-1:0]      used_len;

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_fire;

  // Parse state
  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0] out_value_r, out_value_nxt;
  logic             out_inv_r, out_inv_nxt;

  logic             is_nul;
  logic             is_space;
  logic             is_sign;
  logic             dig_hit;
  logic [DIG_W-1:0] dig_idx;
  logic [ACC_W-1:0] acc_mac;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r    <= '0;
      chars_high_r   <= '0;
      base_length_r  <= '0;
      base_invalid_r <= 1'b1;
    end else begin
      base_invalid_r <= base_invalid_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_CHARS_LOW:  chars_low_r   <= cfg_pwdata;
          REG_CHARS_HIGH: chars_high_r  <= cfg_pwdata;
          REG_LENGTH:     base_length_r <= cfg_pwdata[LEN_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CHARS_LOW:  cfg_prdata = chars_low_r;
      REG_CHARS_HIGH: cfg_prdata = chars_high_r;
      REG_LENGTH:     cfg_prdata = CFG_DATA_W'(base_length_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign chars    = {chars_high_r, chars_low_r};
  // Cap the radix at the number of compared characters
  assign used_len = (base_length_r > LEN_W'(MAX_BASE_CHARS)) ? LEN_W'(MAX_BASE_CHARS)
                                                             : base_length_r;

  bnsi_base_check #(
    .MAX_BASE_CHARS(MAX_BASE_CHARS)
  ) u_base_check (
    .chars      (chars),
    .base_length(base_length_r),
    .invalid    (base_invalid_nxt)
  );

  bnsi_digit_match #(
    .MAX_BASE_CHARS(MAX_BASE_CHARS),
    .DIG_W         (DIG_W)
  ) u_digit_match (
    .chars    (chars),
    .used_len (used_len),
    .character(s1_char_r),
    .hit      (dig_hit),
    .digit    (dig_idx)
  );

  // ---------------- input register ----------------
  // Hold a zero byte only while the previous result is still waiting.
  assign s1_fire  = s1_valid_r && !(is_nul && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_character;
    end
  end

  // ---------------- parse step ----------------
  assign is_nul   = (s1_char_r == CHAR_NUL);
  assign is_space = ((s1_char_r >= CHAR_TAB) && (s1_char_r <= CHAR_CR)) ||
                    (s1_char_r == CHAR_SPACE);
  assign is_sign  = (s1_char_r == CHAR_PLUS) || (s1_char_r == CHAR_MINUS);
  assign acc_mac  = acc_r * ACC_W'(used_len) + ACC_W'(dig_idx);

  always_comb begin
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    out_value_nxt = out_value_r;
    out_inv_nxt   = out_inv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_fire) begin
      if (is_nul) begin
        // Emit the result and go back to the start state
        out_valid_nxt = 1'b1;
        out_inv_nxt   = base_invalid_r;
        if (base_invalid_r) begin
          out_value_nxt = '0;
        end else if (neg_r) begin
          out_value_nxt = '0 - acc_r;
        end else begin
          out_value_nxt = acc_r;
        end
        phase_nxt = PH_SPACE;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end else begin
        case (phase_r)
          PH_SPACE, PH_SIGN: begin
            if (phase_r == PH_SPACE && is_space) begin
              phase_nxt = PH_SPACE;
            end else if (is_sign) begin
              phase_nxt = PH_SIGN;
              neg_nxt   = neg_r ^ (s1_char_r == CHAR_MINUS);
            end else if (dig_hit) begin
              phase_nxt = PH_DIGIT;
              acc_nxt   = acc_mac;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_DIGIT: begin
            if (dig_hit) begin
              acc_nxt = acc_mac;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            // Drop bytes until the terminator
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACE;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_inv_r   <= out_inv_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_base_invalid = out_inv_r;

endmodule

`default_nettype wire

// ===== dv/base_n_string_to_integer_tb.sv =====
`timescale 1ns / 1ps

import bnsi_pkg::*;

typedef struct packed {
  logic signed [ACC_W-1:0] value;
  logic                    base_invalid;
} parse_result_t;

// Tracks the parser state and the base registers, and keeps the results that
// the zero bytes seen so far still owe.
class string_value_tracker;
  logic [CHARS_W-1:0] chars;
  logic [LEN_W-1:0]   length;
  phase_t             phase;
  logic               negative;
  logic [ACC_W-1:0]   acc;
  parse_result_t      awaited_values[$];
  int unsigned        errors;

  function new();
    chars    = '0;
    length   = '0;
    phase    = PH_SPACE;
    negative = 1'b0;
    acc      = '0;
    errors   = 0;
  endfunction

  function void load_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CHARS_LOW:  chars[63:0]   = data;
      REG_CHARS_HIGH: chars[127:64] = data;
      REG_LENGTH:     length        = data[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned radix();
    return (length > MAX_BASE_CHARS_DEF) ? MAX_BASE_CHARS_DEF : length;
  endfunction

  function bit base_rejected();
    logic [7:0] c;
    if (length <= 1 || length > MAX_BASE_CHARS_DEF) return 1'b1;
    for (int i = 0; i < length; i++) begin
      c = chars[8*i +: 8];
      if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b1;
      for (int j = i + 1; j < length; j++)
        if (chars[8*j +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void take_char(logic [7:0] c);
    parse_result_t r;
    bit            bad;
    int            digit;
    int unsigned   n;
    if (c == CHAR_NUL) begin
      bad            = base_rejected();
      r.value        = bad ? '0 : (negative ? 32'd0 - acc : acc);
      r.base_invalid = bad;
      awaited_values.push_back(r);
      phase    = PH_SPACE;
      negative = 1'b0;
      acc      = '0;
      return;
    end
    if (phase == PH_IDLE) return;
    if (phase == PH_SPACE && ((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE)) return;
    if (phase == PH_SPACE || phase == PH_SIGN) begin
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        if (c == CHAR_MINUS) negative = !negative;
        phase = PH_SIGN;
        return;
      end
      phase = PH_DIGIT;
    end
    n     = radix();
    digit = -1;
    for (int k = 0; k < n; k++)
      if (digit < 0 && chars[8*k +: 8] == c) digit = k;
    if (digit < 0) phase = PH_IDLE;
    else acc = acc * 32'(n) + 32'(digit);
  endfunction

  function void check_result(logic signed [ACC_W-1:0] value, logic base_invalid);
    parse_result_t r;
    if (awaited_values.size() == 0) begin
      $error("unexpected result: value %0d base_invalid %0b", value, base_invalid);
      errors++;
      return;
    end
    r = awaited_values.pop_front();
    if (value !== r.value) begin
      $error("value: expected %0d, actual %0d", r.value, value);
      errors++;
    end
    if (base_invalid !== r.base_invalid) begin
      $error("base_invalid: expected %0b, actual %0b", r.base_invalid, base_invalid);
      errors++;
    end
  endfunction
endclass

module base_n_string_to_integer_tb;

  localparam int          CHAR_TARGET = 1350;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          LONG_HOLD   = 300;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [7:0]              in_character;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [ACC_W-1:0] out_value;
  logic                    out_base_invalid;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_ADDR_W-1:0]   cfg_paddr;
  logic [CFG_DATA_W-1:0]   cfg_pwdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  string_value_tracker board;
  int                  chars_sent;
  int unsigned         cycle_count;
  bit                  hold_results;
  bit                  in_steady;
  bit                  out_steady;

  base_n_string_to_integer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_character    (in_character),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_base_invalid(out_base_invalid),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Draw the wait before the next transaction; now and then toggle a steady
  // stretch in which the side never idles.
  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 19) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // Offer one byte and hold it until accepted. Enter and leave on a falling edge.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = draw_wait(in_steady);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_character = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_char(c);
    chars_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Send the text followed by the terminating zero byte.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CHAR_NUL);
  endtask

  function automatic logic [7:0] pick_digit();
    int unsigned n;
    n = board.radix();
    if (n == 0) return 8'($urandom_range(1, 255));
    return board.chars[8*$urandom_range(0, n - 1) +: 8];
  endfunction

  function automatic logic [7:0] pick_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
  endfunction

  // Mostly well-formed numbers in the current base; the rest is noise or
  // numbers with trailing junk. Every string ends with a zero byte.
  task automatic send_random_string();
    int n;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send_char(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) send_char(pick_blank());
      n = $urandom_range(0, 3);
      repeat (n) send_char($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 6);
      repeat (n) send_char(pick_digit());
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) send_char(8'($urandom_range(1, 255)));
      end
    end
    send_char(CHAR_NUL);
  endtask

  // Drain every owed result, then let the pipeline go quiet.
  task automatic settle();
    while (board.awaited_values.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic apb_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.load_register(idx, data);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  function automatic logic [CHARS_W-1:0] pack_chars(input string s);
    logic [CHARS_W-1:0] ch;
    ch = '0;
    for (int k = 0; k < s.len() && k < MAX_BASE_CHARS_DEF; k++) ch[8*k +: 8] = s[k];
    return ch;
  endfunction

  task automatic set_base(input logic [CHARS_W-1:0] ch, input int len);
    settle();
    apb_write(REG_CHARS_LOW, ch[63:0]);
    apb_write(REG_CHARS_HIGH, ch[127:64]);
    apb_write(REG_LENGTH, CFG_DATA_W'(len));
  endtask

  // Walk the fixed bases first (valid, minimal, maximal and each way to be
  // rejected), then random bases with distinct characters.
  task automatic apply_setting(input int idx);
    logic [CHARS_W-1:0] ch;
    logic [255:0]       taken;
    logic [7:0]         b;
    int                 len;
    case (idx)
      0:  begin ch = pack_chars("0123456789");       len = 10; end
      1:  begin ch = pack_chars("0123456789abcdef"); len = 16; end
      2:  begin ch = pack_chars("01");               len = 2;  end
      3:  begin ch = pack_chars("7");                len = 1;  end
      4:  begin ch = pack_chars("0123456789");       len = 0;  end
      5:  begin ch = pack_chars("0123456789ABCDEF"); len = 31; end
      6:  begin ch = pack_chars("0123456789abcdef"); len = 17; end
      7:  begin ch = pack_chars("01+34567");         len = 8;  end
      8:  begin ch = pack_chars("012-");             len = 4;  end
      9:  begin ch = pack_chars("01201");            len = 5;  end
      10: begin
        // zero byte inside the used length
        ch = pack_chars("01");
        ch[31:24] = "3";
        len = 4;
      end
      11: begin ch = pack_chars(" \t\nxyz");         len = 6;  end
      12: begin ch = '1;                             len = 16; end
      default: begin
        taken = '0;
        taken[CHAR_NUL]   = 1'b1;
        taken[CHAR_PLUS]  = 1'b1;
        taken[CHAR_MINUS] = 1'b1;
        for (int k = 0; k < MAX_BASE_CHARS_DEF; k++) begin
          b = 8'($urandom_range(1, 255));
          while (taken[b]) b = 8'($urandom_range(1, 255));
          taken[b] = 1'b1;
          ch[8*k +: 8] = b;
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(2, 16);
      end
    endcase
    set_base(ch, len);
  endtask

  // Result side: random backpressure, plus one long hold on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_results = 1'b0;
      end
      gap = draw_wait(out_steady);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(out_value, out_base_invalid);
    end
  end

  initial begin
    int setting;
    int target;
    board        = new();
    chars_sent   = 0;
    cycle_count  = 0;
    hold_results = 1'b0;
    in_steady    = 1'b0;
    out_steady   = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_character = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Registers still at reset: empty base, rejected.
    send_text("7");

    // Directed strings in decimal: blanks, sign flips, junk stop, overflow,
    // empty string, high and whitespace bytes.
    apply_setting(0);
    send_text(" -+-42z7");
    send_text("9999999999");
    send_text("");
    send_char(CHAR_CR);
    send_char(CHAR_TAB);
    send_char(8'hFF);
    send_char(CHAR_NUL);

    // Random phases, each on a new base. Early on, hold the result side long
    // enough for the block to back up into its input.
    setting = 1;
    while (chars_sent < CHAR_TARGET) begin
      apply_setting(setting);
      if (setting == 3) hold_results = 1'b1;
      setting++;
      target = chars_sent + 100;
      while (chars_sent < target) send_random_string();
    end

    settle();
    repeat (20) @(negedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== base_n_string_to_integer.f =====
hdl/bnsi_pkg.sv
hdl/bnsi_digit_match.sv
hdl/bnsi_base_check.sv
hdl/base_n_string_to_integer.sv
dv/base_n_string_to_integer_tb.sv
